### hdl/dsg_pkg.sv
// shared types and constants for the domino shuffle grid engine
// no dependencies; imported by the top level, dsg_ctrl, dsg_dp and the testbench
`default_nettype none
package dsg_pkg;

    typedef enum logic [2:0] {
        REQ_WRITE  = 3'd0,
        REQ_READ   = 3'd1,
        REQ_MARK   = 3'd2,
        REQ_EXPAND = 3'd3,
        REQ_REMOVE = 3'd4,
        REQ_FILL   = 3'd5
    } req_e;

    localparam logic [2:0] CELL_U      = 3'd1;
    localparam logic [2:0] CELL_D      = 3'd2;
    localparam logic [2:0] CELL_L      = 3'd3;
    localparam logic [2:0] CELL_R      = 3'd4;
    localparam logic [2:0] CELL_EMPTY  = 3'd5;
    localparam logic [2:0] CELL_CORNER = 3'd7;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_CELL_GET, ST_LOOK, ST_GETA, ST_GETB,
        ST_GETC, ST_DECIDE, ST_WBLK, ST_NEXT, ST_RESP
    } state_t;

    // which address the memory port uses this cycle
    typedef enum logic [2:0] {
        ACC_CELL, ACC_A, ACC_B, ACC_C, ACC_EXP, ACC_BLK, ACC_CLR
    } acc_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic       wr_en;
        acc_t       acc;
        logic [1:0] wsel;
        logic       cap_a;
        logic       cap_b;
        logic       cap_c;
        logic       cap_rv;
        logic       draw;
        logic       cnt_next;
        logic       clr_next;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       bad;
        logic       empty;
        logic       last;
        logic       mark_hit;
        logic       exp_hit;
        logic       rem_hit;
        logic       fill_hit;
        logic       clr_last;
    } dp_stat_t;

endpackage
`default_nettype wire

### hdl/domino_shuffle_grid_engine_top.sv
// top level of the domino shuffle grid engine
// depends on dsg_pkg, dsg_ctrl, dsg_dp (which holds dsg_ram)
//
// usage:
//   s_* carries one command word, m_* returns one result word per command.
//   cfg_we/cfg_wdata load the lfsr seed (zero loads as one); write only when idle.
// commands:
//   cell write and cell read each make one access to the cell memory.
//   mark corners: steps over n*n cell positions, plus 4 writes per corner hit.
//   expand: reads n*n source cells, copies U/D/L/R cells shifted into the other bank.
//   remove facing: (n-1)*(n-1) block positions, plus 4 writes per hit.
//   random fill: (n-1)*(n-1) block positions, plus 4 writes per empty top-left cell.
//   all of these share the single-port cell memory, one access per cycle.
// reset:
//   a clearing pass writes zero to all 2**(2*clog2(MAX_SIDE)+1) cells (8192 at the
//   default), one per cycle; s_tready stays low meanwhile.
// stall:
//   a result waits in the output register; the next command is accepted but
//   its result is held back until m_tready takes the waiting word.
`default_nettype none
module domino_shuffle_grid_engine_top #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // req_type[2:0] bank[3] side[10:4] row[16:11] col[22:17] cell_value[25:23]
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_value[2:0] status[3]
    output logic [7:0]       m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);
    import dsg_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    dsg_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );
endmodule
`default_nettype wire

### hdl/dsg_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module dsg_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule
`default_nettype wire

### hdl/dsg_ctrl.sv
// sequencer for the grid engine: handshakes, sweep steps, clearing pass
// depends on dsg_pkg
`default_nettype none
module dsg_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output dsg_pkg::dp_cmd_t      cmd,
    input  wire dsg_pkg::dp_stat_t stat
);
    import dsg_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] wsel_reg, wsel_next;
    logic       mv_reg, mv_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            wsel_reg  <= 2'd0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wsel_reg  <= wsel_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_tvalid = mv_reg;

    always_comb
    begin
        state_next = state_reg;
        wsel_next  = wsel_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.acc    = ACC_CELL;
        cmd.wsel   = wsel_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.acc      = ACC_CLR;
                cmd.clr_next = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (stat.bad)
                begin
                    state_next = ST_RESP;
                end
                else if (stat.req == REQ_WRITE)
                begin
                    cmd.wr_en  = 1'b1;
                    state_next = ST_RESP;
                end
                else if (stat.req == REQ_READ)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CELL_GET;
                end
                else if (stat.req == REQ_MARK)
                begin
                    state_next = stat.empty ? ST_RESP : ST_DECIDE;
                end
                else if (stat.req == REQ_EXPAND || stat.req == REQ_REMOVE ||
                         stat.req == REQ_FILL)
                begin
                    state_next = stat.empty ? ST_RESP : ST_LOOK;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_CELL_GET:
            begin
                cmd.cap_rv = 1'b1;
                state_next = ST_RESP;
            end
            ST_LOOK:
            begin
                cmd.rd_en  = 1'b1;
                cmd.acc    = ACC_A;
                state_next = ST_GETA;
            end
            ST_GETA:
            begin
                cmd.cap_a = 1'b1;
                if (stat.req == REQ_REMOVE)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.acc    = ACC_B;
                    state_next = ST_GETB;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_GETB:
            begin
                cmd.cap_b  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.acc    = ACC_C;
                state_next = ST_GETC;
            end
            ST_GETC:
            begin
                cmd.cap_c  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                wsel_next  = 2'd0;
                state_next = ST_NEXT;
                if (stat.req == REQ_EXPAND)
                begin
                    cmd.acc   = ACC_EXP;
                    cmd.wr_en = stat.exp_hit;
                end
                else if ((stat.req == REQ_MARK && stat.mark_hit) ||
                         (stat.req == REQ_REMOVE && stat.rem_hit))
                begin
                    state_next = ST_WBLK;
                end
                else if (stat.req == REQ_FILL && stat.fill_hit)
                begin
                    cmd.draw   = 1'b1;
                    state_next = ST_WBLK;
                end
            end
            ST_WBLK:
            begin
                cmd.wr_en = 1'b1;
                cmd.acc   = ACC_BLK;
                wsel_next = wsel_reg + 2'd1;
                if (wsel_reg == 2'd3)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (stat.last)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    cmd.cnt_next = 1'b1;
                    state_next   = (stat.req == REQ_MARK) ? ST_DECIDE : ST_LOOK;
                end
            end
            ST_RESP:
            begin
                if (!mv_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            mv_next = 1'b1;
        end
        else if (m_tready)
        begin
            mv_next = 1'b0;
        end
        else
        begin
            mv_next = mv_reg;
        end
    end
endmodule
`default_nettype wire

### hdl/dsg_dp.sv
// datapath: request registers, sweep counters, cell memory, lfsr, result word
// depends on dsg_pkg and dsg_ram
`default_nettype none
module dsg_dp #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [31:0]       s_tdata,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_wdata,
    input  wire dsg_pkg::dp_cmd_t  cmd,
    output dsg_pkg::dp_stat_t      stat,
    output logic [7:0]             m_tdata
);
    import dsg_pkg::*;

    localparam int AW  = $clog2(MAX_SIDE);
    localparam int ADW = 2 * AW + 1;

    logic [2:0]     req_reg;
    logic           bank_reg;
    logic [6:0]     side_reg;
    logic [5:0]     row_reg, col_reg;
    logic [2:0]     val_reg;
    logic           bad_reg;
    logic [6:0]     r_reg, c_reg;
    logic [2:0]     ca_reg, cb_reg, cc_reg;
    logic           fbit_reg;
    logic [31:0]    lfsr_reg;
    logic [2:0]     rv_reg;
    logic [3:0]     out_reg;
    logic [ADW:0]   clr_reg;

    logic [2:0]     in_req;
    logic [6:0]     in_side;
    logic [5:0]     in_row, in_col;
    logic           in_bad;
    logic [6:0]     lim;
    logic           blk_op;
    logic [ADW-1:0] addr;
    logic [2:0]     wdata, rdata;

    function automatic logic [ADW-1:0] mk(input logic b, input logic [6:0] r,
                                          input logic [6:0] c);
        mk = {b, AW'(r), AW'(c)};
    endfunction

    assign in_req  = s_tdata[2:0];
    assign in_side = s_tdata[10:4];
    assign in_row  = s_tdata[16:11];
    assign in_col  = s_tdata[22:17];

    always_comb
    begin
        in_bad = 1'b0;
        if (in_req == REQ_WRITE || in_req == REQ_READ)
        begin
            in_bad = (32'(in_row) >= 32'(MAX_SIDE)) || (32'(in_col) >= 32'(MAX_SIDE));
        end
        else if (in_req == REQ_EXPAND)
        begin
            in_bad = (32'(in_side) + 32'd2) > 32'(MAX_SIDE);
        end
        else if (in_req == REQ_MARK || in_req == REQ_REMOVE || in_req == REQ_FILL)
        begin
            in_bad = 32'(in_side) > 32'(MAX_SIDE);
        end
    end

    // remove and fill work on 2x2 blocks, so their sweep stops one short
    assign blk_op = (req_reg == REQ_REMOVE) || (req_reg == REQ_FILL);
    assign lim    = blk_op ? side_reg - 7'd1 : side_reg;

    always_comb
    begin
        stat          = '0;
        stat.req      = req_reg;
        stat.bad      = bad_reg;
        stat.empty    = (side_reg == 7'd0) || (blk_op && side_reg == 7'd1);
        stat.last     = (r_reg == lim - 7'd1) && (c_reg == lim - 7'd1);
        stat.mark_hit = ({1'b0, r_reg} + {1'b0, c_reg} + 8'd1) < {2'b0, side_reg[6:1]};
        stat.exp_hit  = (ca_reg == CELL_U) || (ca_reg == CELL_D) ||
                        (ca_reg == CELL_L) || (ca_reg == CELL_R);
        stat.rem_hit  = (ca_reg == CELL_R && cb_reg == CELL_L) ||
                        (ca_reg == CELL_D && cc_reg == CELL_U);
        stat.fill_hit = (ca_reg == CELL_EMPTY);
        stat.clr_last = (clr_reg == (ADW + 1)'((1 << ADW) - 1));
    end

    always_comb
    begin
        addr  = mk(bank_reg, r_reg, c_reg);
        wdata = val_reg;
        case (cmd.acc)
            ACC_CELL: addr = mk(bank_reg, {1'b0, row_reg}, {1'b0, col_reg});
            ACC_A:    addr = mk(bank_reg, r_reg, c_reg);
            ACC_B:    addr = mk(bank_reg, r_reg, c_reg + 7'd1);
            ACC_C:    addr = mk(bank_reg, r_reg + 7'd1, c_reg);
            ACC_EXP:
            begin
                wdata = ca_reg;
                if (ca_reg == CELL_U)
                begin
                    addr = mk(~bank_reg, r_reg, c_reg + 7'd1);
                end
                else if (ca_reg == CELL_D)
                begin
                    addr = mk(~bank_reg, r_reg + 7'd2, c_reg + 7'd1);
                end
                else if (ca_reg == CELL_L)
                begin
                    addr = mk(~bank_reg, r_reg + 7'd1, c_reg);
                end
                else
                begin
                    addr = mk(~bank_reg, r_reg + 7'd1, c_reg + 7'd2);
                end
            end
            ACC_BLK:
            begin
                if (req_reg == REQ_MARK)
                begin
                    wdata = CELL_CORNER;
                    case (cmd.wsel)
                        2'd0:    addr = mk(bank_reg, r_reg, c_reg);
                        2'd1:    addr = mk(bank_reg, side_reg - r_reg - 7'd1, c_reg);
                        2'd2:    addr = mk(bank_reg, r_reg, side_reg - c_reg - 7'd1);
                        default: addr = mk(bank_reg, side_reg - r_reg - 7'd1,
                                           side_reg - c_reg - 7'd1);
                    endcase
                end
                else
                begin
                    addr = mk(bank_reg, r_reg + {6'd0, cmd.wsel[1]},
                              c_reg + {6'd0, cmd.wsel[0]});
                    if (req_reg == REQ_REMOVE)
                    begin
                        wdata = CELL_EMPTY;
                    end
                    else if (fbit_reg)
                    begin
                        wdata = cmd.wsel[1] ? CELL_D : CELL_U;
                    end
                    else
                    begin
                        wdata = cmd.wsel[0] ? CELL_R : CELL_L;
                    end
                end
            end
            ACC_CLR:
            begin
                addr  = clr_reg[ADW-1:0];
                wdata = 3'd0;
            end
            default: addr = mk(bank_reg, r_reg, c_reg);
        endcase
    end

    dsg_ram #(
        .WIDTH (3),
        .DEPTH (1 << ADW)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .re    (cmd.rd_en),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            lfsr_reg <= 32'd1;
        end
        else
        begin
            if (cmd.clr_next)
            begin
                clr_reg <= clr_reg + (ADW + 1)'(1);
            end
            if (cfg_we)
            begin
                lfsr_reg <= (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
            end
            else if (cmd.draw)
            begin
                lfsr_reg <= (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : 32'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= in_req;
            bank_reg <= s_tdata[3];
            side_reg <= in_side;
            row_reg  <= in_row;
            col_reg  <= in_col;
            val_reg  <= s_tdata[25:23];
            bad_reg  <= in_bad;
            rv_reg   <= 3'd0;
            r_reg    <= 7'd0;
            c_reg    <= 7'd0;
        end
        else if (cmd.cnt_next)
        begin
            if (c_reg == lim - 7'd1)
            begin
                c_reg <= 7'd0;
                r_reg <= r_reg + 7'd1;
            end
            else
            begin
                c_reg <= c_reg + 7'd1;
            end
        end
        if (cmd.cap_rv)
        begin
            rv_reg <= rdata;
        end
        if (cmd.cap_a)
        begin
            ca_reg <= rdata;
        end
        if (cmd.cap_b)
        begin
            cb_reg <= rdata;
        end
        if (cmd.cap_c)
        begin
            cc_reg <= rdata;
        end
        if (cmd.draw)
        begin
            fbit_reg <= lfsr_reg[0];
        end
        if (cmd.out_load)
        begin
            out_reg <= {bad_reg, rv_reg};
        end
    end

    assign m_tdata = {4'd0, out_reg};
endmodule
`default_nettype wire

### hdl/dsg_chk.sv
// port-level checks for the grid engine, bound to the top level
// no package dependency
`default_nettype none
module dsg_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);
    // a held result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one command at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted while busy");

    // refused commands never return cell data
    a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2:0] == 3'd0)
        else $error("refused command returned data");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:4] == 4'd0)
        else $error("pad bits set");
endmodule

bind domino_shuffle_grid_engine_top dsg_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for domino_shuffle_grid_engine_top
// depends on dsg_pkg and the block rtl; predicts every result word from its own grid copy
`default_nettype none
module testbench;
    import dsg_pkg::*;

    localparam int SIDE_MAX = 64;
    localparam int BANK_SZ  = SIDE_MAX * SIDE_MAX;
    localparam logic [2:0] REQ_NOP6 = 3'd6;
    localparam logic [2:0] REQ_NOP7 = 3'd7;
    localparam int CYCLE_LIMIT = 20_000_000;

    typedef struct {
        logic [2:0] rd_val;
        logic       refused;
    } grid_result_t;

    class grid_scoreboard;
        logic [2:0]   cells [2*BANK_SZ];
        logic [31:0]  lfsr;
        grid_result_t pending [$];
        int           errors;

        function new();
            foreach (cells[i]) cells[i] = 3'd0;
            lfsr = 32'd1;
            errors = 0;
        endfunction

        function void load_seed(logic [31:0] s);
            lfsr = (s == 32'd0) ? 32'd1 : s;
        endfunction

        function int addr(int b, int r, int c);
            return b * BANK_SZ + r * SIDE_MAX + c;
        endfunction

        function void set_block(int b, int r, int c, logic [2:0] tl, logic [2:0] tr,
                                logic [2:0] bl, logic [2:0] br);
            cells[addr(b, r, c)] = tl;
            cells[addr(b, r, c + 1)] = tr;
            cells[addr(b, r + 1, c)] = bl;
            cells[addr(b, r + 1, c + 1)] = br;
        endfunction

        // note one accepted command word and queue its expected result
        function void note_command(logic [31:0] w);
            logic [2:0]   req;
            int           b, n, row, col, t;
            logic [2:0]   val, v;
            logic         bit0;
            grid_result_t res;
            req = w[2:0];
            b = w[3];
            n = w[10:4];
            row = w[16:11];
            col = w[22:17];
            val = w[25:23];
            res.rd_val = 3'd0;
            res.refused = 1'b0;
            case (req)
                REQ_WRITE: cells[addr(b, row, col)] = val;
                REQ_READ:  res.rd_val = cells[addr(b, row, col)];
                REQ_MARK:
                    if (n > SIDE_MAX) res.refused = 1'b1;
                    else
                        for (int r = 0; r < n; r++)
                            for (int c = 0; c < n; c++)
                                if (r + c + 1 < n / 2)
                                begin
                                    cells[addr(b, r, c)] = CELL_CORNER;
                                    cells[addr(b, n - r - 1, c)] = CELL_CORNER;
                                    cells[addr(b, r, n - c - 1)] = CELL_CORNER;
                                    cells[addr(b, n - r - 1, n - c - 1)] = CELL_CORNER;
                                end
                REQ_EXPAND:
                begin
                    t = b ^ 1;
                    if (n + 2 > SIDE_MAX) res.refused = 1'b1;
                    else
                        for (int r = 0; r < n; r++)
                            for (int c = 0; c < n; c++)
                            begin
                                v = cells[addr(b, r, c)];
                                if (v == CELL_U) cells[addr(t, r, c + 1)] = CELL_U;
                                else if (v == CELL_D) cells[addr(t, r + 2, c + 1)] = CELL_D;
                                else if (v == CELL_L) cells[addr(t, r + 1, c)] = CELL_L;
                                else if (v == CELL_R) cells[addr(t, r + 1, c + 2)] = CELL_R;
                            end
                end
                REQ_REMOVE:
                    if (n > SIDE_MAX) res.refused = 1'b1;
                    else
                        for (int r = 0; r + 1 < n; r++)
                            for (int c = 0; c + 1 < n; c++)
                            begin
                                if (cells[addr(b, r, c)] == CELL_R &&
                                    cells[addr(b, r, c + 1)] == CELL_L)
                                    set_block(b, r, c, CELL_EMPTY, CELL_EMPTY,
                                              CELL_EMPTY, CELL_EMPTY);
                                if (cells[addr(b, r, c)] == CELL_D &&
                                    cells[addr(b, r + 1, c)] == CELL_U)
                                    set_block(b, r, c, CELL_EMPTY, CELL_EMPTY,
                                              CELL_EMPTY, CELL_EMPTY);
                            end
                REQ_FILL:
                    if (n > SIDE_MAX) res.refused = 1'b1;
                    else
                        for (int r = 0; r + 1 < n; r++)
                            for (int c = 0; c + 1 < n; c++)
                                if (cells[addr(b, r, c)] == CELL_EMPTY)
                                begin
                                    bit0 = lfsr[0];
                                    lfsr = (lfsr >> 1) ^ (bit0 ? LFSR_TAPS : 32'd0);
                                    if (bit0)
                                        set_block(b, r, c, CELL_U, CELL_U, CELL_D, CELL_D);
                                    else
                                        set_block(b, r, c, CELL_L, CELL_R, CELL_L, CELL_R);
                                end
                default: ;
            endcase
            pending.push_back(res);
        endfunction

        function void check_result(logic [7:0] w);
            grid_result_t e;
            if (pending.size() == 0)
            begin
                $error("result word 0x%02h with nothing expected", w);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w[2:0] !== e.rd_val)
            begin
                $error("read_value expected %0d actual %0d", e.rd_val, w[2:0]);
                errors++;
            end
            if (w[3] !== e.refused)
            begin
                $error("status expected %0d actual %0d", e.refused, w[3]);
                errors++;
            end
            if (w[7:4] !== 4'd0)
            begin
                $error("padding expected 0 actual %0d", w[7:4]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [7:0]  m_tdata;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;
    int          cycles = 0;
    int          out_gap = 0;
    int          out_wait = 0;
    grid_scoreboard sb = new();

    domino_shuffle_grid_engine_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] pack_cmd(logic [2:0] req, logic b, logic [6:0] n,
                                             logic [5:0] row, logic [5:0] col,
                                             logic [2:0] val);
        return {6'd0, val, col, row, n, b, req};
    endfunction

    task automatic send_word(logic [31:0] w);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        // tvalid was just lowered at this edge, so wait for a later edge before raising it
        repeat ((gap == 0) ? 1 : gap) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= w;
        do @(posedge clk); while (!s_tready);
        sb.note_command(w);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge clk);
        // every command has returned its result by now; idle for a long tail anyway
        repeat (40000) @(posedge clk);
    endtask

    task automatic write_seed(logic [31:0] s);
        cfg_we <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.load_seed(s);
    endtask

    // small sides mostly, now and then SIDE_MAX or a side from SIDE_MAX-1 up to 127
    function automatic logic [6:0] pick_side();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return 7'(SIDE_MAX);
        if (k == 1) return 7'($urandom_range(SIDE_MAX - 1, 127));
        return 7'($urandom_range(0, 12));
    endfunction

    task automatic random_cmd();
        logic [2:0] req;
        int k;
        k = $urandom_range(0, 99);
        if (k < 30) req = REQ_WRITE;
        else if (k < 55) req = REQ_READ;
        else if (k < 62) req = REQ_MARK;
        else if (k < 74) req = REQ_EXPAND;
        else if (k < 84) req = REQ_REMOVE;
        else if (k < 94) req = REQ_FILL;
        else req = 3'($urandom_range(6, 7));
        if (req == REQ_WRITE || req == REQ_READ)
            send_word(pack_cmd(req, 1'($urandom), 7'($urandom), 6'($urandom_range(0, 15)),
                               6'($urandom_range(0, 15)), 3'($urandom)));
        else
            send_word(pack_cmd(req, 1'($urandom), pick_side(), 6'($urandom),
                               6'($urandom), 3'($urandom)));
    endtask

    // one shuffling step on bank b at side n
    task automatic shuffle_round(logic b, logic [6:0] n);
        send_word(pack_cmd(REQ_MARK, b, n, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_REMOVE, b, n, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_EXPAND, b, n, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_FILL, !b, n + 7'd2, 6'd0, 6'd0, 3'd0));
        for (int i = 0; i < 3; i++)
            send_word(pack_cmd(REQ_READ, !b, 7'd0, 6'($urandom_range(0, n + 1)),
                               6'($urandom_range(0, n + 1)), 3'd0));
    endtask

    // result side: after each taken word, hold tready low for a drawn number of cycles
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
            out_gap = $urandom_range(0, 19);
            out_wait <= out_gap;
            m_tready <= (out_gap == 0);
        end
        else if (out_wait > 0)
        begin
            out_wait <= out_wait - 1;
            m_tready <= (out_wait == 1);
        end
    end

    initial
    begin
        logic [6:0] n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_seed(32'hFFFF_FFFF);
        // directed: cell extremes, every command, refusals, unused codes
        send_word(pack_cmd(REQ_WRITE, 1'b0, 7'd0, 6'd0, 6'd0, 3'd7));
        send_word(pack_cmd(REQ_WRITE, 1'b1, 7'd127, 6'd63, 6'd63, 3'd5));
        send_word(pack_cmd(REQ_READ, 1'b0, 7'd0, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_READ, 1'b1, 7'd0, 6'd63, 6'd63, 3'd7));
        send_word(pack_cmd(REQ_WRITE, 1'b0, 7'd0, 6'd1, 6'd1, 3'd4));
        send_word(pack_cmd(REQ_WRITE, 1'b0, 7'd0, 6'd1, 6'd2, 3'd3));
        send_word(pack_cmd(REQ_WRITE, 1'b0, 7'd0, 6'd2, 6'd0, 3'd2));
        send_word(pack_cmd(REQ_WRITE, 1'b0, 7'd0, 6'd3, 6'd0, 3'd1));
        send_word(pack_cmd(REQ_REMOVE, 1'b0, 7'd4, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_FILL, 1'b0, 7'd4, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_EXPAND, 1'b0, 7'd4, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_READ, 1'b1, 7'd0, 6'd2, 6'd3, 3'd0));
        send_word(pack_cmd(REQ_MARK, 1'b1, 7'd64, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_READ, 1'b1, 7'd0, 6'd63, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_EXPAND, 1'b0, 7'd63, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_EXPAND, 1'b1, 7'd62, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_MARK, 1'b0, 7'd65, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_REMOVE, 1'b0, 7'd127, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_FILL, 1'b1, 7'd1, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_REMOVE, 1'b1, 7'd0, 6'd0, 6'd0, 3'd0));
        send_word(pack_cmd(REQ_NOP6, 1'b1, 7'd127, 6'd63, 6'd63, 3'd7));
        send_word(pack_cmd(REQ_NOP7, 1'b0, 7'd5, 6'd0, 6'd0, 3'd0));
        wait_drained();
        write_seed(32'd0);
        for (int ph = 0; ph < 3; ph++)
        begin
            n = 7'd2;
            for (int i = 0; i < 4; i++)
            begin
                shuffle_round(1'(i), n);
                n = n + 7'd2;
            end
            for (int i = 0; i < 11; i++) random_cmd();
            wait_drained();
            write_seed(ph == 0 ? 32'd1 : $urandom);
        end
        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
